>>> src/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define BBA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bitmap allocator assertion failed");
// expression must never be true outside reset
`define BBA_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("bitmap allocator forbidden condition");
`else
`define BBA_ASSERT(label, clk, rst, prop)
`define BBA_NEVER(label, clk, rst, expr)
`endif
`endif

>>> src/bba_pkg.sv
// types and constants of the bitmap block allocator
package bba_pkg;

   localparam int MAX_BLOCKS  = 4096;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int BLOCK_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int WORD_CNT_W  = COUNT_W - BIT_IDX_W;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_OUT_OF_BLOCKS = 2'd1,
      STATUS_DOUBLE_FREE   = 2'd2,
      STATUS_RANGE         = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE_CHK,
      ST_DONE
   } state_type;

   // lowest clear bit of one map word
   typedef struct packed {
      logic                 found;
      logic [BIT_IDX_W-1:0] bit_idx;
      logic [WORD_BITS-1:0] onehot;
   } zero_type;

endpackage

>>> src/bba_ram.sv
// generic simple dual port ram with registered read
module bba_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bba_first_zero.sv
// finds the lowest clear bit of one map word
module bba_first_zero (
   input  logic [bba_pkg::WORD_BITS-1:0] word,
   output bba_pkg::zero_type             zero
);

   logic [bba_pkg::WORD_BITS-1:0] inv;
   logic [bba_pkg::WORD_BITS-1:0] low;
   logic [bba_pkg::BIT_IDX_W-1:0] idx;

   // isolate the lowest set bit of the inverted word
   assign inv = ~word;
   assign low = inv & (~inv + bba_pkg::WORD_BITS'(1));

   // one-hot to binary: each index bit is an or over its positions
   always_comb begin
      idx = '0;
      for (int k = 0; k < bba_pkg::BIT_IDX_W; k++) begin
         for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
            if (((i >> k) & 1) == 1) begin
               idx[k] = idx[k] | low[i];
            end
         end
      end
   end

   assign zero.found   = |inv;
   assign zero.bit_idx = idx;
   assign zero.onehot  = low;

endmodule

>>> src/bitmap_block_allocator.sv
// First-fit bitmap block allocator. A free map of MAX_BLOCKS bits sits in a
// 128 x 32 ram; after reset every block is free (per-word valid flops stand in
// for the ram contents, so no clearing pass is needed). An allocate transfer
// scans the map one word per cycle from word 0 through a single lowest-zero
// finder: the ram read of word 0 on acceptance, the scan state, then the done
// state, which loads the response register once the response side is free.
// A free transfer does one ram read, then one check and write. One request is
// worked at a time; req_ready is high only while the sequencer is idle.
// total_blocks above 4096 saturates at 4096, and a count of zero makes every
// allocate report out of blocks.
`include "assert_macros.svh"

module bitmap_block_allocator (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [bba_pkg::BLOCK_W-1:0]  req_block_index,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bba_pkg::BLOCK_W-1:0]  rsp_block_number,
   output logic [1:0]                   rsp_status,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [bba_pkg::COUNT_W-1:0]  csr_wr_data
);

   bba_pkg::state_type                  state_ff, state_in;
   logic [bba_pkg::WORD_CNT_W-1:0]      scan_word_ff, scan_word_in;
   logic [bba_pkg::BLOCK_W-1:0]         free_idx_ff, free_idx_in;
   logic [bba_pkg::BLOCK_W-1:0]         res_number_ff, res_number_in;
   bba_pkg::status_type                 res_status_ff, res_status_in;
   logic                                rsp_valid_ff;
   logic [bba_pkg::BLOCK_W-1:0]         rsp_number_ff;
   bba_pkg::status_type                 rsp_status_ff;
   logic [bba_pkg::COUNT_W-1:0]         total_blocks_ff;
   logic [bba_pkg::MAP_WORDS-1:0]       map_valid_ff;
   logic                                rd_valid_ff;

   logic                                ram_wr_en;
   logic [bba_pkg::WORD_IDX_W-1:0]      ram_wr_addr;
   logic [bba_pkg::WORD_BITS-1:0]       ram_wr_data;
   logic                                ram_rd_en;
   logic [bba_pkg::WORD_IDX_W-1:0]      ram_rd_addr;
   logic [bba_pkg::WORD_BITS-1:0]       ram_rd_data;

   logic                                req_xfer;
   logic                                out_free;
   logic [bba_pkg::COUNT_W-1:0]         count_eff;
   logic [bba_pkg::COUNT_W-1:0]         count_round;
   logic [bba_pkg::WORD_CNT_W-1:0]      scan_words;
   logic [bba_pkg::WORD_CNT_W-1:0]      scan_next;
   logic                                scan_last;
   logic                                idx_range_err;
   logic [bba_pkg::WORD_BITS-1:0]       data_word;
   logic [bba_pkg::WORD_BITS-1:0]       live_bits;
   logic [bba_pkg::WORD_BITS-1:0]       free_bit;
   bba_pkg::zero_type                   zero;

   assign req_ready = (state_ff == bba_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // effective count and number of words to scan
   assign count_eff   = (total_blocks_ff > bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS))
                        ? bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS) : total_blocks_ff;
   assign count_round = count_eff + bba_pkg::COUNT_W'(bba_pkg::WORD_BITS - 1);
   assign scan_words  = count_round[bba_pkg::COUNT_W-1:bba_pkg::BIT_IDX_W];
   assign scan_next   = scan_word_ff + bba_pkg::WORD_CNT_W'(1);
   assign scan_last   = (scan_next == scan_words);
   assign idx_range_err = ({1'b0, req_block_index} >= count_eff);

   // map word as read, unwritten words read as all free
   assign data_word = rd_valid_ff ? ram_rd_data : '0;

   // blocks at or above the count look used in the last word
   assign live_bits = (scan_word_ff < count_eff[bba_pkg::COUNT_W-1:bba_pkg::BIT_IDX_W])
                      ? '1 : ~({bba_pkg::WORD_BITS{1'b1}}
                               << count_eff[bba_pkg::BIT_IDX_W-1:0]);

   assign free_bit = bba_pkg::WORD_BITS'(1) << free_idx_ff[bba_pkg::BIT_IDX_W-1:0];

   bba_first_zero u_first_zero (
      .word (data_word | ~live_bits),
      .zero (zero)
   );

   bba_ram #(
      .WIDTH (bba_pkg::WORD_BITS),
      .DEPTH (bba_pkg::MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_func == bba_pkg::FUNC_ALLOC) begin
                  state_in = (scan_words == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
               end else begin
                  state_in = idx_range_err ? bba_pkg::ST_DONE : bba_pkg::ST_FREE_CHK;
               end
            end
         end
         bba_pkg::ST_SCAN: begin
            if (zero.found || scan_last) begin
               state_in = bba_pkg::ST_DONE;
            end
         end
         bba_pkg::ST_FREE_CHK: begin
            state_in = bba_pkg::ST_DONE;
         end
         bba_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs: ram control and result capture
   always_comb begin
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = scan_word_ff[bba_pkg::WORD_IDX_W-1:0];
      ram_wr_data   = data_word | zero.onehot;
      scan_word_in  = scan_word_ff;
      free_idx_in   = free_idx_ff;
      res_number_in = res_number_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         bba_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_func == bba_pkg::FUNC_ALLOC) begin
                  scan_word_in  = '0;
                  res_number_in = '0;
                  res_status_in = bba_pkg::STATUS_OUT_OF_BLOCKS;
                  ram_rd_en     = (scan_words != '0);
               end else begin
                  free_idx_in   = req_block_index;
                  res_number_in = req_block_index;
                  res_status_in = bba_pkg::STATUS_RANGE;
                  ram_rd_en     = !idx_range_err;
                  ram_rd_addr   = req_block_index[bba_pkg::BLOCK_W-1:bba_pkg::BIT_IDX_W];
               end
            end
         end
         bba_pkg::ST_SCAN: begin
            if (zero.found) begin
               ram_wr_en     = 1'b1;
               res_number_in = {scan_word_ff[bba_pkg::WORD_IDX_W-1:0], zero.bit_idx};
               res_status_in = bba_pkg::STATUS_OK;
            end else if (!scan_last) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = scan_next[bba_pkg::WORD_IDX_W-1:0];
               scan_word_in = scan_next;
            end
         end
         bba_pkg::ST_FREE_CHK: begin
            ram_wr_addr = free_idx_ff[bba_pkg::BLOCK_W-1:bba_pkg::BIT_IDX_W];
            ram_wr_data = data_word & ~free_bit;
            if ((data_word & free_bit) == '0) begin
               res_status_in = bba_pkg::STATUS_DOUBLE_FREE;
            end else begin
               ram_wr_en     = 1'b1;
               res_status_in = bba_pkg::STATUS_OK;
            end
         end
         bba_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bba_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         total_blocks_ff <= bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS);
         map_valid_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            total_blocks_ff <= csr_wr_data;
         end
         if (ram_wr_en) begin
            map_valid_ff[ram_wr_addr] <= 1'b1;
         end
         // response register: load on completion, drop on transfer
         if (state_ff == bba_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_word_ff  <= scan_word_in;
      free_idx_ff   <= free_idx_in;
      res_number_ff <= res_number_in;
      res_status_ff <= res_status_in;
      if (ram_rd_en) begin
         rd_valid_ff <= map_valid_ff[ram_rd_addr];
      end
      if (state_ff == bba_pkg::ST_DONE && out_free) begin
         rsp_number_ff <= res_number_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_number_ff;
   assign rsp_status       = rsp_status_ff;

   // a response only appears after the sequencer has finished
   `BBA_ASSERT(a_rsp_after_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == bba_pkg::ST_DONE))
   // map writes come only from the scan hit or the free check
   `BBA_ASSERT(a_wr_from_work, clock, reset, ram_wr_en |-> (state_ff == bba_pkg::ST_SCAN || state_ff == bba_pkg::ST_FREE_CHK))
   // scan pointer stays inside the words covered by the count
   `BBA_ASSERT(a_scan_in_range, clock, reset, (state_ff == bba_pkg::ST_SCAN) |-> (scan_word_ff < scan_words))
   // a successful allocate or free names a block below the count
   `BBA_ASSERT(a_ok_below_count, clock, reset, (rsp_valid_ff && rsp_status_ff == bba_pkg::STATUS_OK) |-> ({1'b0, rsp_number_ff} < count_eff))
   // never accept a request while a result is still being worked
   `BBA_NEVER(a_no_accept_busy, clock, reset, req_xfer && state_ff != bba_pkg::ST_IDLE)

endmodule

>>> tb/allocation_checker.sv
`timescale 1ns / 1ps
// reply checker for the bitmap block allocator: keeps its own free map and compares every reply
module allocation_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_func,
   input  logic [bba_pkg::BLOCK_W-1:0] req_block_index,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [bba_pkg::BLOCK_W-1:0] rsp_block_number,
   input  logic [1:0]                  rsp_status,
   input  logic                        csr_wr_en,
   input  logic [bba_pkg::COUNT_W-1:0] csr_wr_data,
   output int                          mismatches,
   output int                          replies_due
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [bba_pkg::BLOCK_W-1:0] number;
      bba_pkg::status_type         status;
   } reply_type;

   bit                          block_taken [bba_pkg::MAX_BLOCKS];
   logic [bba_pkg::COUNT_W-1:0] block_count;
   reply_type                   expected_replies [$];

   // apply one request to the free map and return the reply it should give
   function automatic reply_type allocate_or_free(bba_pkg::func_type op,
                                                  logic [bba_pkg::BLOCK_W-1:0] idx);
      reply_type reply;
      int managed;
      managed = (block_count > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS
                                                    : int'(block_count);
      reply.number = '0;
      reply.status = bba_pkg::STATUS_OUT_OF_BLOCKS;
      if (op == bba_pkg::FUNC_ALLOC) begin
         // first fit: lowest free block below the managed count
         for (int b = 0; b < managed && reply.status != bba_pkg::STATUS_OK; b++) begin
            if (!block_taken[b]) begin
               block_taken[b] = 1'b1;
               reply.number = bba_pkg::BLOCK_W'(b);
               reply.status = bba_pkg::STATUS_OK;
            end
         end
      end else begin
         // free echoes the index; errors leave the map alone
         reply.number = idx;
         if (int'(idx) >= managed) begin
            reply.status = bba_pkg::STATUS_RANGE;
         end else if (!block_taken[idx]) begin
            reply.status = bba_pkg::STATUS_DOUBLE_FREE;
         end else begin
            block_taken[idx] = 1'b0;
            reply.status = bba_pkg::STATUS_OK;
         end
      end
      return reply;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < REPORT_LIMIT) $display("%0t reply check: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : track
      reply_type want;
      if (reset) begin
         foreach (block_taken[i]) block_taken[i] = 1'b0;
         block_count = bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS);
         expected_replies.delete();
         mismatches = 0;
      end else begin
         // reply transfer: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("unexpected reply block %0d status %0d",
                                         rsp_block_number, rsp_status));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_block_number !== want.number || rsp_status !== want.status)
                  report_mismatch($sformatf("expected block %0d status %0d, got block %0d status %0d",
                                            want.number, want.status,
                                            rsp_block_number, rsp_status));
            end
         end
         // request transfer: update the map and queue the reply
         if (req_valid && req_ready)
            expected_replies.push_back(allocate_or_free(bba_pkg::func_type'(req_func),
                                                        req_block_index));
         // count register takes effect for later requests
         if (csr_wr_en) block_count = csr_wr_data;
      end
      replies_due = expected_replies.size();
   end

endmodule

>>> tb/bitmap_block_allocator_test.sv
`timescale 1ns / 1ps
// top of the allocator testbench: clock, reset, stimulus, reply side stalls and verdict
module bitmap_block_allocator_test;

   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 140;
   localparam int STALL_LIMIT  = 2000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_func;
   logic [bba_pkg::BLOCK_W-1:0] req_block_index;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [bba_pkg::BLOCK_W-1:0] rsp_block_number;
   logic [1:0]                  rsp_status;
   logic                        csr_wr_en;
   logic [bba_pkg::COUNT_W-1:0] csr_wr_data;

   int mismatches;
   int replies_due;
   int quiet_cycles;
   bit idle_on;
   bit hold_rsp;

   bitmap_block_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   allocation_checker reply_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatches       (mismatches),
      .replies_due      (replies_due)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // idle length: mostly none, some short, a few long
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one request and hold it until the transfer
   task automatic send_request(bba_pkg::func_type op, logic [bba_pkg::BLOCK_W-1:0] idx);
      int gap;
      bit taken;
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= op;
      req_block_index <= idx;
      do begin
         @(posedge clock);
         taken = req_ready;
         @(negedge clock);
      end while (!taken);
   endtask

   // write the count register once every reply is back
   task automatic set_block_count(logic [bba_pkg::COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (replies_due != 0) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // reply side: random stalls, plus one long hold-off on request
   initial begin
      int k;
      bit hold_done;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            k = gap_cycles();
            if (k == 0) begin
               rsp_ready <= 1'b1;
               @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (k) @(negedge clock);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [bba_pkg::COUNT_W-1:0] count;
      logic [bba_pkg::BLOCK_W-1:0] idx;
      int managed;
      int n;
      int alloc_pct;
      int allocs;
      int phase;
      int random_sent;
      int r;
      int t;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = bba_pkg::FUNC_ALLOC;
      req_block_index = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      idle_on         = 1'b1;
      hold_rsp        = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset count: frees of free blocks at both ends, then first fit
      send_request(bba_pkg::FUNC_FREE, '0);
      send_request(bba_pkg::FUNC_FREE, '1);
      send_request(bba_pkg::FUNC_ALLOC, '1);
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_FREE, bba_pkg::BLOCK_W'(1));
      send_request(bba_pkg::FUNC_FREE, bba_pkg::BLOCK_W'(1));
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));

      // zero count manages nothing
      set_block_count('0);
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));
      send_request(bba_pkg::FUNC_FREE, '0);
      send_request(bba_pkg::FUNC_FREE, '1);

      // single block, already taken
      set_block_count(bba_pkg::COUNT_W'(1));
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));
      send_request(bba_pkg::FUNC_FREE, bba_pkg::BLOCK_W'(2));
      send_request(bba_pkg::FUNC_FREE, '0);
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));

      // count above the maximum saturates
      set_block_count('1);
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));
      send_request(bba_pkg::FUNC_FREE, '1);
      set_block_count(bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS));
      send_request(bba_pkg::FUNC_FREE, bba_pkg::BLOCK_W'(3));

      // count lowered to the blocks in use, so none are free
      set_block_count(bba_pkg::COUNT_W'(3));
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));
      send_request(bba_pkg::FUNC_FREE, bba_pkg::BLOCK_W'(2));
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));
      set_block_count(bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS));
      send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));

      // random phases, each with its own count and mix
      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (phase == 2 || (r >= 75 && r < 85))
            count = bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS);
         else if (r < 55) count = bba_pkg::COUNT_W'($urandom_range(1, 40));
         else if (r < 75) count = bba_pkg::COUNT_W'($urandom_range(41, 600));
         else if (r < 92)
            count = bba_pkg::COUNT_W'($urandom_range(bba_pkg::MAX_BLOCKS + 1, 8191));
         else if (r < 96) count = '0;
         else count = bba_pkg::COUNT_W'($urandom_range(601, bba_pkg::MAX_BLOCKS - 1));
         set_block_count(count);
         managed = (count > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : int'(count);

         idle_on = ($urandom_range(0, 99) < 80);
         // long reply hold-off while requests keep coming
         if (phase == 1) hold_rsp = 1'b1;
         // deep fill phase at the full count
         n         = (phase == 2) ? 350 : $urandom_range(40, 120);
         alloc_pct = (phase == 2) ? 90 : $urandom_range(30, 85);
         allocs    = 0;

         repeat (n) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < alloc_pct) begin
               send_request(bba_pkg::FUNC_ALLOC, bba_pkg::BLOCK_W'($urandom));
               allocs++;
            end else begin
               // frees aim mostly at blocks likely in use, some at the count edge
               if (r < 65) begin
                  idx = bba_pkg::BLOCK_W'($urandom_range(0, allocs + 8));
               end else if (r < 85) begin
                  t = managed - 1 + $urandom_range(0, 2);
                  if (t < 0) t = 0;
                  if (t > bba_pkg::MAX_BLOCKS - 1) t = bba_pkg::MAX_BLOCKS - 1;
                  idx = bba_pkg::BLOCK_W'(t);
               end else begin
                  idx = bba_pkg::BLOCK_W'($urandom);
               end
               send_request(bba_pkg::FUNC_FREE, idx);
            end
         end
         random_sent += n;
         phase++;
      end

      // drain and let the block settle
      req_valid <= 1'b0;
      while (replies_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && replies_due == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> bitmap_block_allocator.f
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_first_zero.sv
src/bitmap_block_allocator.sv
tb/allocation_checker.sv
tb/bitmap_block_allocator_test.sv
